// File: rtl/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the IR pulse-distance frame decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Frame geometry
    localparam int FRAME_BITS = 32;
    localparam int CNT_W      = $clog2(FRAME_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);
    localparam int SHIFT_W    = 32;
    localparam int PERIOD_W   = 16;
    localparam int BYTE_W     = 8;

    // Configuration port geometry
    localparam int NUM_REGS   = 5;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int IDX_W      = 3;

    // Register indexes
    typedef enum logic [IDX_W-1:0] {
        REG_LEADER_MIN    = 3'd0,
        REG_LEADER_MAX    = 3'd1,
        REG_BIT_MIN       = 3'd2,
        REG_BIT_MAX       = 3'd3,
        REG_ONE_THRESHOLD = 3'd4
    } reg_idx_t;

    // Reset values, microsecond ticks
    localparam logic [PERIOD_W-1:0] RST_LEADER_MIN    = 16'd12500;
    localparam logic [PERIOD_W-1:0] RST_LEADER_MAX    = 16'd14285;
    localparam logic [PERIOD_W-1:0] RST_BIT_MIN       = 16'd1000;
    localparam logic [PERIOD_W-1:0] RST_BIT_MAX       = 16'd3333;
    localparam logic [PERIOD_W-1:0] RST_ONE_THRESHOLD = 16'd2000;

    typedef struct packed {
        logic [PERIOD_W-1:0] leader_min;
        logic [PERIOD_W-1:0] leader_max;
        logic [PERIOD_W-1:0] bit_min;
        logic [PERIOD_W-1:0] bit_max;
        logic [PERIOD_W-1:0] one_threshold;
    } cfg_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_ARMED = 1'b1
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] command;
        logic              frame_ok;
    } result_t;

endpackage

// File: rtl/ir_pulse_distance_frame_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Decodes pulse-distance IR remote frames from measured edge-to-edge periods.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                       Contents
//  s_axis    in   s_tvalid/s_tready/s_tdata     period_us [15:0]
//  m_axis    out  m_tvalid/m_tready/m_tdata     address [7:0], command [15:8]
//                 m_tuser                       frame_ok [0]
//  apb       in   psel/penable/pwrite/paddr     five 16-bit registers at 4*i
//
//  One period is taken per clock unless an untaken result stalls the input.
//  A period is classified and shifted into the frame while it sits in the
//  input register, and a finished frame lands in the result register at the
//  next edge. Any held period waits while the result register holds an
//  untaken result, so the input stalls once the input register is full and
//  the result register holds an untaken result. Reset clears the frame
//  state and both valid flags and loads the default windows.
//
module ir_pulse_distance_frame_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [irpd_pkg::PERIOD_W-1:0]      s_tdata,   // [15:0] period_us
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [2*irpd_pkg::BYTE_W-1:0]      m_tdata,   // [7:0] address, [15:8] command
    output logic                               m_tuser,   // [0] frame_ok
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    irpd_pkg::cfg_t                   cfg;
    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic [irpd_pkg::PERIOD_W-1:0]    period_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    irpd_pkg::result_t                result_reg;
    logic                             advance;
    logic                             in_xfer;
    logic                             res_valid;
    irpd_pkg::result_t                res;

    irpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Process the held period whenever the result register can take a result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    irpd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .period    (period_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            period_reg <= s_tdata;
        end
        if (advance && res_valid)
        begin
            result_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {result_reg.command, result_reg.address};
    assign m_tuser  = result_reg.frame_ok;

endmodule

// File: rtl/irpd_cfg.sv
// ----------------------------------------------------------------------------
// irpd_cfg
// APB register bank holding the period windows and the one-threshold.
// ----------------------------------------------------------------------------
module irpd_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output irpd_pkg::cfg_t                     cfg
);

    irpd_pkg::cfg_t                   cfg_reg;
    logic                             wr_en;
    logic [irpd_pkg::IDX_W-1:0]       idx;
    logic [irpd_pkg::PERIOD_W-1:0]    wval;
    logic [irpd_pkg::PERIOD_W-1:0]    rval;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[irpd_pkg::APB_ADDR_W-1:2];
    assign wval   = pwdata[irpd_pkg::PERIOD_W-1:0];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.leader_min    <= irpd_pkg::RST_LEADER_MIN;
            cfg_reg.leader_max    <= irpd_pkg::RST_LEADER_MAX;
            cfg_reg.bit_min       <= irpd_pkg::RST_BIT_MIN;
            cfg_reg.bit_max       <= irpd_pkg::RST_BIT_MAX;
            cfg_reg.one_threshold <= irpd_pkg::RST_ONE_THRESHOLD;
        end
        else if (wr_en)
        begin
            unique case (idx)
                irpd_pkg::REG_LEADER_MIN:    cfg_reg.leader_min    <= wval;
                irpd_pkg::REG_LEADER_MAX:    cfg_reg.leader_max    <= wval;
                irpd_pkg::REG_BIT_MIN:       cfg_reg.bit_min       <= wval;
                irpd_pkg::REG_BIT_MAX:       cfg_reg.bit_max       <= wval;
                irpd_pkg::REG_ONE_THRESHOLD: cfg_reg.one_threshold <= wval;
                default:                     ;  // drop writes past the list
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            irpd_pkg::REG_LEADER_MIN:    rval = cfg_reg.leader_min;
            irpd_pkg::REG_LEADER_MAX:    rval = cfg_reg.leader_max;
            irpd_pkg::REG_BIT_MIN:       rval = cfg_reg.bit_min;
            irpd_pkg::REG_BIT_MAX:       rval = cfg_reg.bit_max;
            irpd_pkg::REG_ONE_THRESHOLD: rval = cfg_reg.one_threshold;
            default:                     rval = '0;
        endcase
        prdata = {{(irpd_pkg::APB_DATA_W - irpd_pkg::PERIOD_W){1'b0}}, rval};
    end

endmodule

// File: rtl/irpd_frame.sv
// ----------------------------------------------------------------------------
// irpd_frame
// Leader/bit classification, frame state and shift register, frame check.
// ----------------------------------------------------------------------------
module irpd_frame (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic [irpd_pkg::PERIOD_W-1:0]     period,
    input  irpd_pkg::cfg_t                    cfg,
    output logic                              res_valid,
    output irpd_pkg::result_t                 res
);

    irpd_pkg::state_t                 state_reg;
    irpd_pkg::state_t                 state_next;
    logic [irpd_pkg::CNT_W-1:0]       count_reg;
    logic [irpd_pkg::CNT_W-1:0]       count_next;
    logic [irpd_pkg::SHIFT_W-1:0]     shift_reg;
    logic [irpd_pkg::SHIFT_W-1:0]     shift_next;

    logic                             leader_hit;
    logic                             bit_hit;
    logic                             bit_val;
    logic                             armed_now;
    logic                             take_bit;
    logic                             last_bit;
    logic [irpd_pkg::SHIFT_W-1:0]     shifted;

    assign leader_hit = (period > cfg.leader_min) && (period < cfg.leader_max);
    assign bit_hit    = (period > cfg.bit_min) && (period < cfg.bit_max);
    assign bit_val    = (period >= cfg.one_threshold);
    // A leader seen while idle counts as armed for the same period
    assign armed_now  = (state_reg == irpd_pkg::ST_ARMED) || leader_hit;
    assign take_bit   = step && armed_now && bit_hit;
    assign last_bit   = (count_reg == irpd_pkg::CNT_LAST);
    assign shifted    = {shift_reg[irpd_pkg::SHIFT_W-2:0], bit_val};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        shift_next = shift_reg;
        if (step && armed_now)
        begin
            state_next = irpd_pkg::ST_ARMED;
        end
        if (take_bit)
        begin
            if (last_bit)
            begin
                state_next = irpd_pkg::ST_IDLE;
                count_next = '0;
                shift_next = '0;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                shift_next = shifted;
            end
        end
    end

    // Outputs
    always_comb
    begin
        res_valid    = take_bit && last_bit;
        res.address  = shifted[31:24];
        res.command  = shifted[15:8];
        res.frame_ok = (shifted[31:24] == ~shifted[23:16]) &&
                       (shifted[15:8]  == ~shifted[7:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= irpd_pkg::ST_IDLE;
            count_reg <= '0;
            shift_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            shift_reg <= shift_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == irpd_pkg::ST_IDLE) |-> (count_reg == '0))
        else $error("bit count nonzero while idle");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> (state_reg == irpd_pkg::ST_IDLE) && (shift_reg == '0))
        else $error("frame state not cleared after result");

    a_bit_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (take_bit && !last_bit) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("bit count did not advance on a data bit");

    a_no_step_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(state_reg) && $stable(count_reg) && $stable(shift_reg))
        else $error("frame state moved without an item");
`endif

endmodule
